// ----- hw/rtl/ldrs_pkg.sv -----
// shared types for the look disk request scheduler
`default_nettype none

package ldrs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_SCAN,
        ST_PICK_SCAN,
        ST_PICK_WAIT,
        ST_PICK_CHECK,
        ST_FINISH
    } ldrs_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;   // capture the input item
        logic scan_clear; // restart index, drop best candidate
        logic scan_step;  // read slot at index, advance index
        logic reverse;    // flip sweep, go to the far end, forget track
        logic commit;     // update state and load the result register
    } ldrs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pick;
        logic empty;
        logic full;
        logic idx_last;
        logic free_hit;
        logic best_found;
        logic out_free;
    } ldrs_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ldrs_if.sv -----
// request and response channel interfaces
`default_nettype none

interface ldrs_req_if #(
    parameter int TRACK_BITS  = 16,
    parameter int SECTOR_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [TRACK_BITS-1:0]  req_track;
    logic [SECTOR_BITS-1:0] req_sector;

    modport source (output valid, output command, output req_track, output req_sector,
                    input ready);
    modport sink   (input valid, input command, input req_track, input req_sector,
                    output ready);
endinterface

interface ldrs_rsp_if #(
    parameter int TRACK_BITS  = 16,
    parameter int SECTOR_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic                   add_accepted;
    logic                   served_valid;
    logic [TRACK_BITS-1:0]  served_track;
    logic [SECTOR_BITS-1:0] served_sector;
    logic                   queue_empty;

    modport source (output valid, output add_accepted, output served_valid,
                    output served_track, output served_sector, output queue_empty,
                    input ready);
    modport sink   (input valid, input add_accepted, input served_valid,
                    input served_track, input served_sector, input queue_empty,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ldrs_ram.sv -----
// generic single-write single-read ram with registered read data
`default_nettype none

module ldrs_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ldrs_ctrl.sv -----
// sequencing state machine for add and pick commands
`default_nettype none

module ldrs_ctrl
    import ldrs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire ldrs_status_t status,
    output ldrs_cmd_t         cmd
);

    ldrs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.scan_clear = 1'b1;
                if (status.is_pick)
                begin
                    state_next = status.empty ? ST_FINISH : ST_PICK_SCAN;
                end
                else
                begin
                    state_next = status.full ? ST_FINISH : ST_ADD_SCAN;
                end
            end
            ST_ADD_SCAN:
            begin
                // index stops on the lowest free slot
                if (status.free_hit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_PICK_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_PICK_WAIT;
                end
            end
            ST_PICK_WAIT:
            begin
                state_next = ST_PICK_CHECK;
            end
            ST_PICK_CHECK:
            begin
                if (status.best_found)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // sweep exhausted, second pass always finds one
                    cmd.reverse    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_PICK_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ldrs_dp.sv -----
// slot store, sweep state, scan compare and result register
`default_nettype none

module ldrs_dp
    import ldrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16,
    parameter int SECTOR_BITS = 20
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   command,
    input  wire logic [TRACK_BITS-1:0]  req_track,
    input  wire logic [SECTOR_BITS-1:0] req_sector,
    input  wire ldrs_cmd_t              cmd,
    output ldrs_status_t                status,
    ldrs_rsp_if.source                  rsp
);

    localparam int IDXW  = $clog2(QUEUE_DEPTH);
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
    localparam int WIDTH = TRACK_BITS + SECTOR_BITS;
    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(QUEUE_DEPTH);
    localparam logic [IDXW-1:0] LAST_IDX   = IDXW'(QUEUE_DEPTH - 1);

    logic [QUEUE_DEPTH-1:0] used_reg, used_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic                   sweep_down_reg, sweep_down_next;
    logic [SECTOR_BITS-1:0] cursor_reg, cursor_next;
    logic                   edge_reg, edge_next;
    logic [TRACK_BITS-1:0]  last_track_reg, last_track_next;
    logic                   ltv_reg, ltv_next;

    logic                   cmd_pick_reg;
    logic [TRACK_BITS-1:0]  req_track_reg;
    logic [SECTOR_BITS-1:0] req_sector_reg;

    logic [IDXW-1:0]        idx_reg, idx_next;
    logic                   rd_valid_reg;
    logic [IDXW-1:0]        rd_slot_reg;
    logic                   best_found_reg, best_found_next;
    logic [IDXW-1:0]        best_slot_reg, best_slot_next;
    logic [TRACK_BITS-1:0]  best_track_reg, best_track_next;
    logic [SECTOR_BITS-1:0] best_sector_reg, best_sector_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_acc_reg, out_acc_next;
    logic                   out_sv_reg, out_sv_next;
    logic [TRACK_BITS-1:0]  out_trk_reg, out_trk_next;
    logic [SECTOR_BITS-1:0] out_sec_reg, out_sec_next;
    logic                   out_empty_reg, out_empty_next;

    logic [WIDTH-1:0]       rd_data;
    logic [TRACK_BITS-1:0]  rd_track;
    logic [SECTOR_BITS-1:0] rd_sector;
    logic                   eligible, better, take;
    logic                   full, empty, do_add, do_serve;

    ldrs_ram #(
        .WIDTH (WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (do_add),
        .wr_addr (idx_reg),
        .wr_data ({req_track_reg, req_sector_reg}),
        .rd_en   (cmd.scan_step),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign rd_track  = rd_data[WIDTH-1:SECTOR_BITS];
    assign rd_sector = rd_data[SECTOR_BITS-1:0];

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign do_add   = cmd.commit && !cmd_pick_reg && !full;
    assign do_serve = cmd.commit && cmd_pick_reg && !empty;

    // candidate check on the slot read last cycle
    always_comb
    begin
        eligible = rd_valid_reg && used_reg[rd_slot_reg]
                   && !(ltv_reg && (rd_track == last_track_reg));
        if (!edge_reg)
        begin
            if (sweep_down_reg)
            begin
                eligible = eligible && (rd_sector <= cursor_reg);
            end
            else
            begin
                eligible = eligible && (rd_sector >= cursor_reg);
            end
        end
        // ties go to the lower slot going up, the higher slot going down
        better = sweep_down_reg ? (rd_sector >= best_sector_reg)
                                : (rd_sector < best_sector_reg);
        take   = eligible && (!best_found_reg || better);
    end

    always_comb
    begin
        used_next        = used_reg;
        count_next       = count_reg;
        sweep_down_next  = sweep_down_reg;
        cursor_next      = cursor_reg;
        edge_next        = edge_reg;
        last_track_next  = last_track_reg;
        ltv_next         = ltv_reg;
        idx_next         = idx_reg;
        best_found_next  = best_found_reg;
        best_slot_next   = best_slot_reg;
        best_track_next  = best_track_reg;
        best_sector_next = best_sector_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_acc_next     = out_acc_reg;
        out_sv_next      = out_sv_reg;
        out_trk_next     = out_trk_reg;
        out_sec_next     = out_sec_reg;
        out_empty_next   = out_empty_reg;

        if (take)
        begin
            best_found_next  = 1'b1;
            best_slot_next   = rd_slot_reg;
            best_track_next  = rd_track;
            best_sector_next = rd_sector;
        end
        if (cmd.scan_step)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.scan_clear)
        begin
            idx_next        = '0;
            best_found_next = 1'b0;
        end
        if (cmd.reverse)
        begin
            sweep_down_next = !sweep_down_reg;
            edge_next       = 1'b1;
            ltv_next        = 1'b0;
        end
        if (do_add)
        begin
            used_next[idx_reg] = 1'b1;
            count_next         = count_reg + 1'b1;
        end
        if (do_serve)
        begin
            used_next[best_slot_reg] = 1'b0;
            count_next               = count_reg - 1'b1;
            cursor_next              = best_sector_reg;
            edge_next                = 1'b0;
            last_track_next          = best_track_reg;
            ltv_next                 = 1'b1;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_acc_next   = do_add;
            out_sv_next    = do_serve;
            out_trk_next   = do_serve ? best_track_reg : '0;
            out_sec_next   = do_serve ? best_sector_reg : '0;
            out_empty_next = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            count_reg      <= '0;
            sweep_down_reg <= 1'b0;
            cursor_reg     <= '0;
            edge_reg       <= 1'b1;
            last_track_reg <= '0;
            ltv_reg        <= 1'b0;
            rd_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            count_reg      <= count_next;
            sweep_down_reg <= sweep_down_next;
            cursor_reg     <= cursor_next;
            edge_reg       <= edge_next;
            last_track_reg <= last_track_next;
            ltv_reg        <= ltv_next;
            rd_valid_reg   <= cmd.scan_step;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cmd_pick_reg   <= command;
            req_track_reg  <= req_track;
            req_sector_reg <= req_sector;
        end
        idx_reg         <= idx_next;
        rd_slot_reg     <= idx_reg;
        best_slot_reg   <= best_slot_next;
        best_track_reg  <= best_track_next;
        best_sector_reg <= best_sector_next;
        out_acc_reg     <= out_acc_next;
        out_sv_reg      <= out_sv_next;
        out_trk_reg     <= out_trk_next;
        out_sec_reg     <= out_sec_next;
        out_empty_reg   <= out_empty_next;
    end

    assign status.is_pick    = cmd_pick_reg;
    assign status.empty      = empty;
    assign status.full       = full;
    assign status.idx_last   = (idx_reg == LAST_IDX);
    assign status.free_hit   = !used_reg[idx_reg];
    assign status.best_found = best_found_reg;
    assign status.out_free   = !out_valid_reg || rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.add_accepted  = out_acc_reg;
    assign rsp.served_valid  = out_sv_reg;
    assign rsp.served_track  = out_trk_reg;
    assign rsp.served_sector = out_sec_reg;
    assign rsp.queue_empty   = out_empty_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/look_disk_request_scheduler_unit.sv -----
// top level of the look disk request scheduler
//
//  channel  modport  contents
//  req      sink     command, req_track, req_sector
//  rsp      source   add_accepted, served_valid, served_track, served_sector, queue_empty
//
// one item at a time; req is ready only while the controller is idle
// add: dispatch, scan up to the lowest free slot, finish (full queue: dispatch, finish)
// pick: dispatch, scan of the slot ram one slot per cycle, wait, check, finish; a sweep
//   reversal repeats scan, wait and check (empty queue: dispatch, finish)
// the result waits in an output register, the next transfer is taken meanwhile
// reset clears all slots at once through their used bits
`default_nettype none

module look_disk_request_scheduler_unit
    import ldrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16,
    parameter int SECTOR_BITS = 20
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ldrs_req_if.sink   req,
    ldrs_rsp_if.source rsp
);

    ldrs_cmd_t    cmd;
    ldrs_status_t status;
    logic         req_ready;

    ldrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ldrs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TRACK_BITS  (TRACK_BITS),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (req.command),
        .req_track  (req.req_track),
        .req_sector (req.req_sector),
        .cmd        (cmd),
        .status     (status),
        .rsp        (rsp)
    );

    assign req.ready = req_ready;

endmodule

`default_nettype wire

// ----- test/tb_look_disk_request_scheduler_unit.sv -----
// self-checking testbench for the look disk request scheduler
module tb_look_disk_request_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int TRACK_BITS  = 16;
    localparam int SECTOR_BITS = 20;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic                   add_accepted;
        logic                   served_valid;
        logic [TRACK_BITS-1:0]  served_track;
        logic [SECTOR_BITS-1:0] served_sector;
        logic                   queue_empty;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ldrs_req_if #(.TRACK_BITS(TRACK_BITS), .SECTOR_BITS(SECTOR_BITS)) req_ch ();
    ldrs_rsp_if #(.TRACK_BITS(TRACK_BITS), .SECTOR_BITS(SECTOR_BITS)) rsp_ch ();

    look_disk_request_scheduler_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TRACK_BITS  (TRACK_BITS),
        .SECTOR_BITS (SECTOR_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // scheduler state as the testbench tracks it
    logic                   slot_busy [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0]  slot_trk  [QUEUE_DEPTH];
    logic [SECTOR_BITS-1:0] slot_sec  [QUEUE_DEPTH];
    logic                   heading_down;
    logic [SECTOR_BITS-1:0] head_sector;
    logic                   head_at_end;
    logic [TRACK_BITS-1:0]  prev_track;
    logic                   prev_track_set;

    sched_result_t due_responses[$];
    int            error_count = 0;
    bit            sender_idle = 1'b1;
    bit            receiver_idle = 1'b1;
    int            drain_hold = 0;

    function automatic int look_choose_slot();
        int best;
        int i;
        best = -1;
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (!slot_busy[i])
                continue;
            if (prev_track_set && slot_trk[i] == prev_track)
                continue;
            if (!head_at_end)
            begin
                if (!heading_down && slot_sec[i] < head_sector)
                    continue;
                if (heading_down && slot_sec[i] > head_sector)
                    continue;
            end
            if (best < 0)
                best = i;
            else if (!heading_down && slot_sec[i] < slot_sec[best])
                best = i;
            else if (heading_down && slot_sec[i] >= slot_sec[best])
                best = i;
        end
        return best;
    endfunction

    function automatic sched_result_t next_service(input logic cmd,
                                                   input logic [TRACK_BITS-1:0] trk,
                                                   input logic [SECTOR_BITS-1:0] sec);
        sched_result_t res;
        int            slot;
        int            i;
        bit            any_busy;
        res = '0;
        any_busy = 1'b0;
        for (i = 0; i < QUEUE_DEPTH; i++)
            any_busy |= slot_busy[i];
        if (cmd == CMD_ADD)
        begin
            for (i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!slot_busy[i])
                begin
                    slot_busy[i] = 1'b1;
                    slot_trk[i] = trk;
                    slot_sec[i] = sec;
                    res.add_accepted = 1'b1;
                    break;
                end
            end
        end
        else if (any_busy)
        begin
            slot = look_choose_slot();
            // sweep ran dry: turn around at the far end and forget the track
            if (slot < 0)
            begin
                heading_down = !heading_down;
                head_at_end = 1'b1;
                prev_track_set = 1'b0;
                slot = look_choose_slot();
            end
            if (slot >= 0)
            begin
                slot_busy[slot] = 1'b0;
                res.served_valid = 1'b1;
                res.served_track = slot_trk[slot];
                res.served_sector = slot_sec[slot];
                head_sector = slot_sec[slot];
                head_at_end = 1'b0;
                prev_track = slot_trk[slot];
                prev_track_set = 1'b1;
            end
        end
        res.queue_empty = 1'b1;
        for (i = 0; i < QUEUE_DEPTH; i++)
            if (slot_busy[i])
                res.queue_empty = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // valid is left high after a transfer so a zero gap keeps it high
    task automatic send_request(input logic cmd, input logic [TRACK_BITS-1:0] trk,
                                input logic [SECTOR_BITS-1:0] sec);
        int gap;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.req_track  <= trk;
        req_ch.req_sector <= sec;
        do @(posedge clk); while (!req_ch.ready);
        due_responses.push_back(next_service(cmd, trk, sec));
    endtask

    task automatic send_random_item(input int add_pct);
        logic                   cmd;
        logic [TRACK_BITS-1:0]  trk;
        logic [SECTOR_BITS-1:0] sec;
        int                     tsel;
        int                     ssel;
        cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_PICK;
        tsel = $urandom_range(0, 9);
        ssel = $urandom_range(0, 9);
        // narrow ranges make same-track skips and sector ties common
        if (tsel < 4)
            trk = TRACK_BITS'($urandom);
        else if (tsel < 8)
            trk = TRACK_BITS'($urandom_range(0, 3));
        else if (tsel == 8)
            trk = '0;
        else
            trk = '1;
        if (ssel < 5)
            sec = SECTOR_BITS'($urandom);
        else if (ssel < 8)
            sec = SECTOR_BITS'($urandom_range(0, 15));
        else if (ssel == 8)
            sec = '0;
        else
            sec = '1;
        send_request(cmd, trk, sec);
    endtask

    task automatic run_bursts(input int total);
        int sent;
        int shape;
        int n;
        sent = 0;
        while (sent < total)
        begin
            shape = $urandom_range(0, 9);
            if (shape < 5)
            begin
                // fill then drain, often past full and past empty
                n = $urandom_range(1, QUEUE_DEPTH + 1);
                repeat (n) send_random_item(100);
                sent += n;
                n = $urandom_range(1, QUEUE_DEPTH + 2);
                repeat (n) send_random_item(0);
                sent += n;
            end
            else if (shape < 8)
            begin
                repeat (8) send_random_item(50);
                sent += 8;
            end
            else if (shape == 8)
            begin
                repeat (4) send_random_item(20);
                sent += 4;
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_random_item(0);
                sent += n;
            end
        end
    endtask

    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (due_responses.size() != 0);
    endtask

    task automatic test_directed();
        int i;
        send_request(CMD_PICK, '0, '0);
        send_request(CMD_ADD, 16'h0000, 20'h00000);
        send_request(CMD_ADD, 16'hFFFF, 20'hFFFFF);
        send_request(CMD_ADD, 16'h0000, 20'h00010);
        send_request(CMD_ADD, 16'h0001, 20'h00010);
        for (i = 4; i < QUEUE_DEPTH; i++)
            send_request(CMD_ADD, TRACK_BITS'(i * 16'h1111), SECTOR_BITS'(i * 20'h11111));
        // queue is full, this one is dropped
        send_request(CMD_ADD, 16'h4321, 20'h12345);
        repeat (6) send_request(CMD_PICK, '1, '1);
    endtask

    task automatic test_random_traffic();
        run_bursts(1400);
    endtask

    task automatic test_back_to_back();
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        run_bursts(200);
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    task automatic test_output_stall();
        sender_idle = 1'b0;
        drain_hold = 300;
        repeat (QUEUE_DEPTH) send_random_item(100);
        repeat (QUEUE_DEPTH) send_random_item(0);
        sender_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (6)
        begin
            run_bursts(10);
            pause_until_drained();
        end
    endtask

    initial
    begin : stimulus
        int i;
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_trk[i] = '0;
            slot_sec[i] = '0;
        end
        heading_down = 1'b0;
        head_sector = '0;
        head_at_end = 1'b1;
        prev_track = '0;
        prev_track_set = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_ADD;
        req_ch.req_track = '0;
        req_ch.req_sector = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_back_to_back();
        test_output_stall();
        test_drain_pause();
        pause_until_drained();
        // catch any stray result after the last expected one
        repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
        if (error_count == 0 && due_responses.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : response_sink
        int hold;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (drain_hold > 0)
            begin
                hold = drain_hold;
                drain_hold = 0;
            end
            else
                hold = receiver_idle ? $urandom_range(0, 14) : 0;
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    always @(posedge clk)
    begin : check_responses
        sched_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_responses.size() == 0)
                report_mismatch("transfer with no result pending, valid",
                                32'(rsp_ch.valid), 32'(0));
            else
            begin
                want = due_responses.pop_front();
                if (rsp_ch.add_accepted !== want.add_accepted)
                    report_mismatch("add_accepted", 32'(rsp_ch.add_accepted),
                                    32'(want.add_accepted));
                if (rsp_ch.served_valid !== want.served_valid)
                    report_mismatch("served_valid", 32'(rsp_ch.served_valid),
                                    32'(want.served_valid));
                if (rsp_ch.served_track !== want.served_track)
                    report_mismatch("served_track", 32'(rsp_ch.served_track),
                                    32'(want.served_track));
                if (rsp_ch.served_sector !== want.served_sector)
                    report_mismatch("served_sector", 32'(rsp_ch.served_sector),
                                    32'(want.served_sector));
                if (rsp_ch.queue_empty !== want.queue_empty)
                    report_mismatch("queue_empty", 32'(rsp_ch.queue_empty),
                                    32'(want.queue_empty));
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
